FILE: rtl/dvd_pkg.sv
// ----------------------------------------------------------------------------
// Date validate and day difference package
// Shared types, constants and calendar tables for the date pipeline.
// ----------------------------------------------------------------------------
package dvd_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 6;
  localparam int unsigned DN_W    = 24;
  localparam int unsigned OUT_W   = 23;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned MOFF_W  = 9;
  localparam int unsigned LEN_W   = 5;

  typedef logic [YEAR_W-1:0]         year_t;
  typedef logic [MONTH_W-1:0]        month_t;
  typedef logic [DAY_W-1:0]          day_t;
  typedef logic signed [DN_W-1:0]    dn_t;
  typedef logic signed [OUT_W-1:0]   out_num_t;
  typedef logic [IDX_W-1:0]          reg_idx_t;
  typedef logic [MOFF_W-1:0]         moff_t;
  typedef logic [LEN_W-1:0]          mlen_t;

  typedef enum logic [1:0] {
    STATUS_VALID     = 2'd0,
    STATUS_YEAR_BAD  = 2'd1,
    STATUS_MONTH_BAD = 2'd2,
    STATUS_DAY_BAD   = 2'd3
  } status_e;

  typedef enum logic [IDX_W-1:0] {
    REG_MIN_YEAR = 2'd0,
    REG_MAX_YEAR = 2'd1
  } reg_idx_e;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pipe_en_t;

  localparam year_t  MIN_YEAR_RST = 14'd1500;
  localparam year_t  MAX_YEAR_RST = 14'd2019;
  localparam month_t MONTH_MAR    = 4'd3;
  localparam month_t MONTH_FEB    = 4'd2;
  localparam month_t MONTH_DEC    = 4'd12;

  // The year is biased by 400 so that all floor divisions see a positive value.
  localparam logic [YEAR_W:0]   YEAR_BIAS   = 15'd400;
  localparam logic [12:0]       RECIP_25    = 13'd5243;
  localparam int unsigned       RECIP_SHIFT = 17;
  localparam logic [DN_W-1:0]   DN_OFFSET   = 24'd146403;
  localparam logic [DN_W-1:0]   DAYS_YEAR   = 24'd365;

  // Day offset of a month in the March-based year, indexed by the raw month.
  localparam moff_t MONTH_OFFSET [16] = '{
    9'd275, 9'd306, 9'd337, 9'd0,   9'd31,  9'd61,  9'd92,  9'd122,
    9'd153, 9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337, 9'd367
  };

  // Month length in a common year; months outside 1..12 have no days.
  localparam mlen_t MONTH_DAYS [16] = '{
    5'd0,  5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0,  5'd0,  5'd0
  };

endpackage

FILE: rtl/dvd_in_if.sv
// ----------------------------------------------------------------------------
// Date pair input channel
// Valid/ready channel that carries the two dates of one item.
// ----------------------------------------------------------------------------
interface dvd_in_if import dvd_pkg::*; ();

  logic   valid;
  logic   ready;
  year_t  year_a;
  month_t month_a;
  day_t   day_a;
  year_t  year_b;
  month_t month_b;
  day_t   day_b;

  modport source (
    output valid, year_a, month_a, day_a, year_b, month_b, day_b,
    input  ready
  );

  modport sink (
    input  valid, year_a, month_a, day_a, year_b, month_b, day_b,
    output ready
  );

endinterface

FILE: rtl/dvd_out_if.sv
// ----------------------------------------------------------------------------
// Date result output channel
// Valid/ready channel that carries the status and day numbers of one item.
// ----------------------------------------------------------------------------
interface dvd_out_if import dvd_pkg::*; ();

  logic        valid;
  logic        ready;
  logic [1:0]  status_a;
  logic [1:0]  status_b;
  out_num_t    day_number_a;
  out_num_t    day_difference;
  logic        is_less;
  logic        is_equal;

  modport source (
    output valid, status_a, status_b, day_number_a, day_difference, is_less, is_equal,
    input  ready
  );

  modport sink (
    input  valid, status_a, status_b, day_number_a, day_difference, is_less, is_equal,
    output ready
  );

endinterface

FILE: rtl/dvd_date_path.sv
// ----------------------------------------------------------------------------
// Date path
// Three register stages that check one date and compute its day number.
// ----------------------------------------------------------------------------
module dvd_date_path import dvd_pkg::*; (
  input  logic     clk_i,
  input  pipe_en_t en_i,
  input  year_t    min_year_i,
  input  year_t    max_year_i,
  input  year_t    year_i,
  input  month_t   month_i,
  input  day_t     day_i,
  output status_e  status_o,
  output dn_t      day_number_o
);

  logic            early;
  logic [YEAR_W:0] u_d, u_q;
  year_t           y_q;
  month_t          m_q;
  day_t            d_q;
  moff_t           moff_q;
  logic [26:0]     ydiv_d, ydiv_q;
  logic            yr_bad_d, yr_bad_q;

  assign early    = month_i < MONTH_MAR;
  assign u_d      = {1'b0, year_i} + YEAR_BIAS - {{YEAR_W{1'b0}}, early};
  assign ydiv_d   = 27'(year_i) * 27'(RECIP_25);
  assign yr_bad_d = (year_i < min_year_i) || (year_i > max_year_i);

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      u_q      <= u_d;
      y_q      <= year_i;
      m_q      <= month_i;
      d_q      <= day_i;
      moff_q   <= MONTH_OFFSET[month_i];
      ydiv_q   <= ydiv_d;
      yr_bad_q <= yr_bad_d;
    end
  end

  logic [12:0]     q4;
  logic [10:0]     q16;
  logic [DN_W-1:0] p365_d, p365_q;
  logic [25:0]     p100_d, p100_q;
  logic [23:0]     p400_d, p400_q;
  logic [12:0]     q4_q;
  moff_t           moff2_q;
  day_t            d2_q;
  logic [9:0]      yq;
  logic            div25;
  logic            leap;
  mlen_t           mlen;
  status_e         status_d, status2_q;

  assign q4     = u_q[YEAR_W:2];
  assign q16    = u_q[YEAR_W:4];
  assign p365_d = DN_W'(u_q) * DAYS_YEAR;
  assign p100_d = 26'(q4) * 26'(RECIP_25);
  assign p400_d = 24'(q16) * 24'(RECIP_25);
  assign yq     = ydiv_q[26:RECIP_SHIFT];
  assign div25  = y_q == (YEAR_W'(yq) * 14'd25);
  assign leap   = div25 ? (y_q[3:0] == 4'd0) : (y_q[1:0] == 2'd0);
  assign mlen   = MONTH_DAYS[m_q] + LEN_W'((m_q == MONTH_FEB) && leap);

  always_comb begin
    if (yr_bad_q) begin
      status_d = STATUS_YEAR_BAD;
    end else if ((m_q == '0) || (m_q > MONTH_DEC)) begin
      status_d = STATUS_MONTH_BAD;
    end else if ((d_q == '0) || (d_q > DAY_W'(mlen))) begin
      status_d = STATUS_DAY_BAD;
    end else begin
      status_d = STATUS_VALID;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      p365_q    <= p365_d;
      p100_q    <= p100_d;
      p400_q    <= p400_d;
      q4_q      <= q4;
      moff2_q   <= moff_q;
      d2_q      <= d_q;
      status2_q <= status_d;
    end
  end

  logic [DN_W-1:0] dn_sum;
  dn_t             dn_q;
  status_e         status3_q;

  assign dn_sum = p365_q + DN_W'(q4_q) - DN_W'(p100_q[25:RECIP_SHIFT])
                + DN_W'(p400_q[23:RECIP_SHIFT]) + DN_W'(moff2_q) + DN_W'(d2_q)
                - DN_OFFSET;

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      dn_q      <= dn_t'(dn_sum);
      status3_q <= status2_q;
    end
  end

  assign status_o     = status3_q;
  assign day_number_o = dn_q;

endmodule

FILE: rtl/date_validate_and_day_difference_unit.sv
// ----------------------------------------------------------------------------
// Date validate and day difference unit
// Checks two Gregorian dates, gives the day number of the first date, the
// signed difference between them and the order flags.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake          Contents
//  in_i     sink       valid/ready        two dates (year, month, day)
//  out_o    source     valid/ready        status pair, day number, difference, flags
//  cfg      input      cfg_we_i           year bounds, index in cfg_idx_i
//
// A transfer enters every cycle unless a stalled output has filled every stage.
// The stages are the two date paths (three stages) and the output register.
// Reset clears the stage valid bits and loads the default year bounds.
// A stalled output holds its data; empty stages still fill, so input
// transfers continue until every stage is occupied.
// ----------------------------------------------------------------------------
module date_validate_and_day_difference_unit import dvd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  reg_idx_t  cfg_idx_i,
  input  year_t     cfg_wdata_i,
  dvd_in_if.sink    in_i,
  dvd_out_if.source out_o
);

  year_t min_year_q, max_year_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_year_q <= MIN_YEAR_RST;
      max_year_q <= MAX_YEAR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MIN_YEAR: min_year_q <= cfg_wdata_i;
        REG_MAX_YEAR: max_year_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic     v1_q, v2_q, v3_q, v4_q;
  logic     en4;
  pipe_en_t en;

  assign en4   = !v4_q || out_o.ready;
  assign en.s3 = !v3_q || en4;
  assign en.s2 = !v2_q || en.s3;
  assign en.s1 = !v1_q || en.s2;

  assign in_i.ready = en.s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en.s1) begin
        v1_q <= in_i.valid;
      end
      if (en.s2) begin
        v2_q <= v1_q;
      end
      if (en.s3) begin
        v3_q <= v2_q;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
    end
  end

  status_e status_a, status_b;
  dn_t     dn_a, dn_b;

  dvd_date_path u_path_a (
    .clk_i        (clk_i),
    .en_i         (en),
    .min_year_i   (min_year_q),
    .max_year_i   (max_year_q),
    .year_i       (in_i.year_a),
    .month_i      (in_i.month_a),
    .day_i        (in_i.day_a),
    .status_o     (status_a),
    .day_number_o (dn_a)
  );

  dvd_date_path u_path_b (
    .clk_i        (clk_i),
    .en_i         (en),
    .min_year_i   (min_year_q),
    .max_year_i   (max_year_q),
    .year_i       (in_i.year_b),
    .month_i      (in_i.month_b),
    .day_i        (in_i.day_b),
    .status_o     (status_b),
    .day_number_o (dn_b)
  );

  logic [DN_W:0] diff;
  status_e       status_a_q, status_b_q;
  out_num_t      dn_a_q, diff_q;
  logic          less_q, equal_q;

  assign diff = {dn_a[DN_W-1], dn_a} - {dn_b[DN_W-1], dn_b};

  always_ff @(posedge clk_i) begin
    if (en4) begin
      status_a_q <= status_a;
      status_b_q <= status_b;
      dn_a_q     <= out_num_t'(dn_a[OUT_W-1:0]);
      diff_q     <= out_num_t'(diff[OUT_W-1:0]);
      less_q     <= dn_a < dn_b;
      equal_q    <= dn_a == dn_b;
    end
  end

  assign out_o.valid          = v4_q;
  assign out_o.status_a       = status_a_q;
  assign out_o.status_b       = status_b_q;
  assign out_o.day_number_a   = dn_a_q;
  assign out_o.day_difference = diff_q;
  assign out_o.is_less        = less_q;
  assign out_o.is_equal       = equal_q;

endmodule

FILE: tb/date_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date result checker
// Watches the date pair and result channels and the year bound port. For
// every accepted date pair it works out the status of both dates, the day
// number of the first, the difference and the order flags. It then compares
// each accepted result, field by field, with the oldest prediction still
// waiting.
// ----------------------------------------------------------------------------
module date_result_checker import dvd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  reg_idx_t cfg_idx_i,
  input  year_t    cfg_wdata_i,
  dvd_in_if        in_mon,
  dvd_out_if       out_mon,
  output int       fail_count_o,
  output int       pending_o,
  output int       checked_o
);

  typedef struct packed {
    status_e  status_a;
    status_e  status_b;
    out_num_t day_number_a;
    out_num_t day_difference;
    logic     is_less;
    logic     is_equal;
  } date_result_t;

  year_t        lo_year;
  year_t        hi_year;
  date_result_t expected_q[$];

  function automatic longint floor_quot(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic status_e date_status(year_t y, month_t m, day_t d);
    int  len;
    logic leap;
    if (y < lo_year || y > hi_year) return STATUS_YEAR_BAD;
    if (m < 1 || m > 12) return STATUS_MONTH_BAD;
    leap = ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    case (m)
      4, 6, 9, 11: len = 30;
      MONTH_FEB:   len = leap ? 29 : 28;
      default:     len = 31;
    endcase
    if (d < 1 || d > len) return STATUS_DAY_BAD;
    return STATUS_VALID;
  endfunction

  // The year is taken to start in March, so January and February count as
  // months 13 and 14 of the year before.
  function automatic longint rata_die(year_t y, month_t m, day_t d);
    longint yy;
    longint mm;
    longint dd;
    yy = longint'(y);
    mm = longint'(m);
    dd = longint'(d);
    if (mm < 3) begin
      yy = yy - 1;
      mm = mm + 12;
    end
    return 365 * yy + floor_quot(yy, 4) - floor_quot(yy, 100) + floor_quot(yy, 400)
         + (153 * mm - 457) / 5 + dd - 306;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    date_result_t exp_r;
    longint       num_a;
    longint       num_b;
    if (!rst_ni) begin
      lo_year = MIN_YEAR_RST;
      hi_year = MAX_YEAR_RST;
      expected_q.delete();
      fail_count_o = 0;
      pending_o = 0;
      checked_o = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          if (fail_count_o < 10) begin
            $display("%0t: result transfer with no prediction waiting", $time);
          end
          fail_count_o++;
        end else begin
          exp_r = expected_q.pop_front();
          checked_o++;
          if (out_mon.status_a !== exp_r.status_a || out_mon.status_b !== exp_r.status_b ||
              out_mon.day_number_a !== exp_r.day_number_a ||
              out_mon.day_difference !== exp_r.day_difference ||
              out_mon.is_less !== exp_r.is_less || out_mon.is_equal !== exp_r.is_equal) begin
            if (fail_count_o < 10) begin
              $display("%0t: result %0d expected st %0d/%0d dn %0d diff %0d lt %0b eq %0b",
                       $time, checked_o, exp_r.status_a, exp_r.status_b,
                       exp_r.day_number_a, exp_r.day_difference, exp_r.is_less,
                       exp_r.is_equal);
              $display("%0t: result %0d actual   st %0d/%0d dn %0d diff %0d lt %0b eq %0b",
                       $time, checked_o, out_mon.status_a, out_mon.status_b,
                       out_mon.day_number_a, out_mon.day_difference, out_mon.is_less,
                       out_mon.is_equal);
            end
            fail_count_o++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        num_a = rata_die(in_mon.year_a, in_mon.month_a, in_mon.day_a);
        num_b = rata_die(in_mon.year_b, in_mon.month_b, in_mon.day_b);
        exp_r.status_a       = date_status(in_mon.year_a, in_mon.month_a, in_mon.day_a);
        exp_r.status_b       = date_status(in_mon.year_b, in_mon.month_b, in_mon.day_b);
        exp_r.day_number_a   = out_num_t'(num_a);
        exp_r.day_difference = out_num_t'(num_a - num_b);
        exp_r.is_less        = num_a < num_b;
        exp_r.is_equal       = num_a == num_b;
        expected_q.push_back(exp_r);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MIN_YEAR: lo_year = cfg_wdata_i;
          REG_MAX_YEAR: hi_year = cfg_wdata_i;
          default: ;
        endcase
      end
      pending_o = expected_q.size();
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date validate and day difference testbench
// Drives directed and random date pairs through the unit under several year
// bound settings and handshake pacing modes; a checker beside the unit
// predicts and compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import dvd_pkg::*;

  localparam int       LATENCY        = 4;
  localparam int       CYCLE_LIMIT    = 500000;
  localparam int       RANDOM_PER_SEG = 190;
  localparam reg_idx_t REG_SPARE_A    = 2'd2;
  localparam reg_idx_t REG_SPARE_B    = 2'd3;

  logic     clk_i;
  logic     rst_ni;
  logic     cfg_we_i;
  reg_idx_t cfg_idx_i;
  year_t    cfg_wdata_i;

  int    fail_count;
  int    pending;
  int    checked;
  int    items_sent     = 0;
  int    settings_used  = 1;
  int    cycle_count    = 0;
  int    send_idle_pct  = 19;
  int    recv_stall_pct = 19;
  year_t cur_min        = MIN_YEAR_RST;
  year_t cur_max        = MAX_YEAR_RST;

  dvd_in_if  in_ch ();
  dvd_out_if out_ch ();

  date_validate_and_day_difference_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  date_result_checker u_result_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic year_t pick_year(year_t lo, year_t hi);
    int v;
    case ($urandom_range(9))
      0, 1: v = $urandom_range(1, 9999);
      2: v = int'(lo) - 2 + int'($urandom_range(0, 4));
      3: v = int'(hi) - 2 + int'($urandom_range(0, 4));
      4: v = 400 * $urandom_range(1, 24);
      5: v = 100 * $urandom_range(1, 99);
      6: v = 4 * $urandom_range(1, 2499);
      7: begin
        case ($urandom_range(3))
          0: v = 1;
          1: v = 9999;
          2: v = 8191;
          default: v = 8192;
        endcase
      end
      default: v = (lo <= hi) ? $urandom_range(lo, hi) : $urandom_range(hi, lo);
    endcase
    if (v < 1) v = 1;
    if (v > 9999) v = 9999;
    return year_t'(v);
  endfunction

  function automatic month_t pick_month();
    if ($urandom_range(9) < 8) return month_t'($urandom_range(1, 12));
    return month_t'($urandom_range(0, 15));
  endfunction

  function automatic day_t pick_day();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return day_t'($urandom_range(1, 28));
      6, 7: return day_t'($urandom_range(27, 32));
      default: return day_t'($urandom_range(0, 63));
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer
  // with valid still high, so the next call decides whether it drops.
  task automatic send_dates(input year_t ya, input month_t ma, input day_t da,
                            input year_t yb, input month_t mb, input day_t db);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.year_a  <= ya;
    in_ch.month_a <= ma;
    in_ch.day_a   <= da;
    in_ch.year_b  <= yb;
    in_ch.month_b <= mb;
    in_ch.day_b   <= db;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_random_pair();
    year_t  ya;
    year_t  yb;
    month_t ma;
    month_t mb;
    day_t   da;
    day_t   db;
    ya = pick_year(cur_min, cur_max);
    ma = pick_month();
    da = pick_day();
    case ($urandom_range(9))
      0, 1: begin
        yb = ya;
        mb = ma;
        db = da;
      end
      2: begin
        yb = ya;
        mb = ma;
        db = $urandom_range(1) ? da + 6'd1 : da - 6'd1;
      end
      3: begin
        yb = ya;
        mb = month_t'($urandom_range(0, 15));
        db = da;
      end
      4: begin
        // Month zero of one year lands on December of the year before.
        ma = 4'd0;
        yb = (ya > 1) ? ya - 14'd1 : ya;
        mb = MONTH_DEC;
        db = da;
      end
      default: begin
        yb = pick_year(cur_min, cur_max);
        mb = pick_month();
        db = pick_day();
      end
    endcase
    send_dates(ya, ma, da, yb, mb, db);
  endtask

  task automatic pause_until_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (LATENCY + 2) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_t idx, input year_t data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_bounds(input year_t lo, input year_t hi);
    write_reg(REG_MIN_YEAR, lo);
    write_reg(REG_MAX_YEAR, hi);
    cur_min = lo;
    cur_max = hi;
    settings_used++;
  endtask

  initial begin
    int    seg_lo [6] = '{1, 1600, 5000, 1, 9999, 1};
    int    seg_hi [6] = '{9999, 2400, 4000, 8191, 9999, 1};
    year_t lo;
    year_t hi;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_MIN_YEAR;
    cfg_wdata_i   = '0;
    in_ch.valid   = 1'b0;
    in_ch.year_a  = '0;
    in_ch.month_a = '0;
    in_ch.day_a   = '0;
    in_ch.year_b  = '0;
    in_ch.month_b = '0;
    in_ch.day_b   = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed pairs under the reset bounds of 1500 to 2019.
    send_dates(14'd2019, 4'd12, 6'd31, 14'd1500, 4'd1, 6'd1);
    send_dates(14'd1499, 4'd6, 6'd15, 14'd2020, 4'd6, 6'd15);
    send_dates(14'd2000, 4'd2, 6'd29, 14'd1900, 4'd2, 6'd29);
    send_dates(14'd2000, 4'd2, 6'd30, 14'd1904, 4'd2, 6'd29);
    send_dates(14'd1600, 4'd2, 6'd29, 14'd2004, 4'd2, 6'd29);
    send_dates(14'd2000, 4'd4, 6'd31, 14'd2000, 4'd1, 6'd32);
    send_dates(14'd2000, 4'd0, 6'd10, 14'd1999, 4'd12, 6'd10);
    send_dates(14'd2001, 4'd13, 6'd1, 14'd2001, 4'd15, 6'd63);
    send_dates(14'd2001, 4'd14, 6'd0, 14'd2001, 4'd1, 6'd0);
    send_dates(14'd2019, 4'd1, 6'd63, 14'd2019, 4'd12, 6'd31);
    send_dates(14'd1, 4'd1, 6'd1, 14'd9999, 4'd15, 6'd63);
    send_dates(14'd9999, 4'd15, 6'd63, 14'd1, 4'd0, 6'd0);
    send_dates(14'd8192, 4'd8, 6'd8, 14'd8191, 4'd7, 6'd7);
    send_dates(14'd2010, 4'd5, 6'd5, 14'd2010, 4'd5, 6'd5);
    send_dates(14'd2010, 4'd5, 6'd4, 14'd2010, 4'd5, 6'd5);
    send_dates(14'd2010, 4'd5, 6'd6, 14'd2010, 4'd5, 6'd5);
    send_dates(14'd2018, 4'd11, 6'd30, 14'd2018, 4'd11, 6'd31);
    send_dates(14'd1500, 4'd1, 6'd1, 14'd2019, 4'd12, 6'd31);
    send_dates(14'd1, 4'd2, 6'd29, 14'd4, 4'd2, 6'd29);
    send_dates(14'd100, 4'd2, 6'd29, 14'd400, 4'd2, 6'd29);
    send_dates(14'd2019, 4'd6, 6'd31, 14'd2019, 4'd9, 6'd30);
    send_dates(14'd2000, 4'd0, 6'd0, 14'd1, 4'd1, 6'd0);

    for (int seg = 0; seg < 8; seg++) begin
      pause_until_drained();
      if (seg < 6) begin
        lo = year_t'(seg_lo[seg]);
        hi = year_t'(seg_hi[seg]);
      end else if (seg == 6) begin
        lo = year_t'($urandom_range(1, 9999));
        hi = year_t'($urandom_range(lo, 9999));
      end else begin
        hi = year_t'($urandom_range(1, 9998));
        lo = year_t'($urandom_range(hi + 1, 9999));
      end
      set_bounds(lo, hi);
      if (seg == 1) begin
        write_reg(REG_SPARE_A, 14'd8191);
        write_reg(REG_SPARE_B, 14'd4096);
      end
      case (seg % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 84;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 84;
        end
        default: begin
          send_idle_pct  = 19;
          recv_stall_pct = 19;
        end
      endcase
      repeat (RANDOM_PER_SEG) begin
        if ($urandom_range(199) == 0) pause_until_drained();
        send_random_pair();
      end
    end

    pause_until_drained();
    $display("Run covered %0d date pairs and %0d checked results over %0d year bound settings.",
             items_sent, checked, settings_used);
    $display("Pacing went through free flow, sparse sending, heavy stalls and mixed idling.");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
